[hdl/frb_pkg.sv]
`default_nettype none

package frb_pkg;

  // Field and register widths
  localparam int CNT_W     = 16;
  localparam int MIN_REQ_W = 16;
  localparam int WORD_W    = 32;
  localparam int THR_W     = 8;
  localparam int MAXIDX_W  = 5;
  localparam int MULT_W    = 8;
  localparam int PCT_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  // Fibonacci lookup
  localparam int FIB_DEPTH          = 48;
  localparam int FIB_IDX_W          = 6;
  localparam int FIB_INDEX_LIMIT_DEF = 24;

  // Scale constants
  localparam int MS_PER_SEC   = 1000;
  localparam int MS_W         = 10;
  localparam int PERCENT_BASE = 100;

  // Shared divider widths
  localparam int DIV_NUM_W = 40;
  localparam int DIV_DEN_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FIB    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_MULT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PCT    = 2'd3;

  // Configuration reset values
  localparam logic [THR_W-1:0]    NOTIFY_THR_RST = 8'd3;
  localparam logic [MAXIDX_W-1:0] MAX_FIB_RST    = 5'd7;
  localparam logic [MULT_W-1:0]   WAIT_MULT_RST  = 8'd1;
  localparam logic [PCT_W-1:0]    MIN_PCT_RST    = 7'd30;

  localparam logic [WORD_W-1:0] FIB_TABLE [FIB_DEPTH] = '{
    32'd0,          32'd1,          32'd1,          32'd2,
    32'd3,          32'd5,          32'd8,          32'd13,
    32'd21,         32'd34,         32'd55,         32'd89,
    32'd144,        32'd233,        32'd377,        32'd610,
    32'd987,        32'd1597,       32'd2584,       32'd4181,
    32'd6765,       32'd10946,      32'd17711,      32'd28657,
    32'd46368,      32'd75025,      32'd121393,     32'd196418,
    32'd317811,     32'd514229,     32'd832040,     32'd1346269,
    32'd2178309,    32'd3524578,    32'd5702887,    32'd9227465,
    32'd14930352,   32'd24157817,   32'd39088169,   32'd63245986,
    32'd102334155,  32'd165580141,  32'd267914296,  32'd433494437,
    32'd701408733,  32'd1134903170, 32'd1836311903, 32'd2971215073
  };

  typedef struct packed {
    logic                 func;
    logic                 tunnel_enabled;
    logic [MIN_REQ_W-1:0] min_delay_secs;
    logic [WORD_W-1:0]    random_value;
  } frb_in_t;

  typedef struct packed {
    logic              schedule;
    logic [WORD_W-1:0] delay_ms;
    logic              clear_cache;
    logic              notify_down;
    logic              notify_error;
    logic [CNT_W-1:0]  attempt_count;
  } frb_out_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic fib_ld;
    logic mul1_ld;
    logic mul2_ld;
    logic pct_ld;
    logic div_start;
    logic div_sel_rem;
    logic minw_ld;
    logic delay_zero;
    logic delay_min;
    logic delay_add;
    logic out_ld;
  } frb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_close;
    logic is_disabled;
    logic zero_max;
    logic min_ge_max;
    logic div_done;
  } frb_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FIB,
    ST_MUL1,
    ST_MUL2,
    ST_PCT,
    ST_DIVQ,
    ST_WAITQ,
    ST_MINW,
    ST_SPAN,
    ST_WAITR,
    ST_FINISH
  } frb_state_e;

endpackage

`default_nettype wire

[hdl/frb_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle
module frb_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [frb_pkg::DIV_NUM_W-1:0] dividend_i,
  input  wire logic [frb_pkg::DIV_DEN_W-1:0] divisor_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic [frb_pkg::DIV_NUM_W-1:0]      quotient_o,
  output logic [frb_pkg::DIV_DEN_W-1:0]      remainder_o
);

  localparam int NUM_W = frb_pkg::DIV_NUM_W;
  localparam int DEN_W = frb_pkg::DIV_DEN_W;
  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q, den_d;

  logic [DEN_W:0]    rem_shift;
  logic [DEN_W:0]    rem_diff;
  logic              fits;

  // Shift in the next dividend bit and try to subtract
  always_comb begin
    rem_shift = {rem_q, quo_q[NUM_W-1]};
    rem_diff  = rem_shift - {1'b0, den_q};
    fits      = (rem_shift >= {1'b0, den_q});
  end

  always_comb begin
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      step_d = STEP_W'(NUM_W);
      busy_d = 1'b1;
      quo_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      quo_d  = {quo_q[NUM_W-2:0], fits};
      rem_d  = fits ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  // Remainder stays below the divisor once the pass ends
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < den_q))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

[hdl/frb_datapath.sv]
`default_nettype none

module frb_datapath #(
  parameter int FIB_INDEX_LIMIT = frb_pkg::FIB_INDEX_LIMIT_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [frb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [frb_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  wire frb_pkg::frb_in_t              in_data_i,
  input  wire frb_pkg::frb_cmd_t             cmd_i,
  output frb_pkg::frb_sts_t                  sts_o,
  output frb_pkg::frb_out_t                  out_data_o
);

  localparam int CNT_W  = frb_pkg::CNT_W;
  localparam int WORD_W = frb_pkg::WORD_W;
  localparam int NUM_W  = frb_pkg::DIV_NUM_W;
  localparam int MS_W   = frb_pkg::MS_W;
  localparam int TBL_W  = frb_pkg::FIB_IDX_W;
  localparam int IDX_W  = $clog2(FIB_INDEX_LIMIT + 1);
  localparam int P1_W   = WORD_W + frb_pkg::MULT_W;
  localparam int P2_W   = P1_W + MS_W;
  localparam int REQ_W  = frb_pkg::MIN_REQ_W + MS_W;

  // Configuration registers
  logic [frb_pkg::THR_W-1:0]    thr_q;
  logic [frb_pkg::MAXIDX_W-1:0] max_fib_q;
  logic [frb_pkg::MULT_W-1:0]   mult_q;
  logic [frb_pkg::PCT_W-1:0]    pct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= frb_pkg::NOTIFY_THR_RST;
      max_fib_q <= frb_pkg::MAX_FIB_RST;
      mult_q    <= frb_pkg::WAIT_MULT_RST;
      pct_q     <= frb_pkg::MIN_PCT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        frb_pkg::CFG_NOTIFY_THR: thr_q     <= cfg_data_i[frb_pkg::THR_W-1:0];
        frb_pkg::CFG_MAX_FIB:    max_fib_q <= cfg_data_i[frb_pkg::MAXIDX_W-1:0];
        frb_pkg::CFG_WAIT_MULT:  mult_q    <= cfg_data_i[frb_pkg::MULT_W-1:0];
        frb_pkg::CFG_MIN_PCT:    pct_q     <= cfg_data_i[frb_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Attempt counter: clear on close, saturating increment on failure
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.accept) begin
      if (in_data_i.func) begin
        cnt_d = '0;
      end else if (cnt_q != '1) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Hold the accepted item
  logic                          func_q;
  logic                          en_q;
  logic [frb_pkg::MIN_REQ_W-1:0] min_req_q;
  logic [WORD_W-1:0]             rnd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q    <= in_data_i.func;
      en_q      <= in_data_i.tunnel_enabled;
      min_req_q <= in_data_i.min_delay_secs;
      rnd_q     <= in_data_i.random_value;
    end
  end

  // Clamp the count to the configured and the built-in index limits
  logic [CNT_W-1:0] clamp_a, clamp_b;
  logic [IDX_W-1:0] fib_idx;

  always_comb begin
    clamp_a = (cnt_q > CNT_W'(max_fib_q)) ? CNT_W'(max_fib_q) : cnt_q;
    clamp_b = (clamp_a > CNT_W'(FIB_INDEX_LIMIT)) ? CNT_W'(FIB_INDEX_LIMIT) : clamp_a;
    fib_idx = IDX_W'(clamp_b);
  end

  // Window arithmetic in stages loaded by the controller commands
  logic [WORD_W-1:0] fib_q;
  logic [P1_W-1:0]   prod1_q;
  logic [P2_W-1:0]   prod2;
  logic [WORD_W-1:0] maxw_q;
  logic [NUM_W-1:0]  pprod_q;
  logic [REQ_W-1:0]  req_ms_q;
  logic [WORD_W-1:0] minw_q;
  logic [WORD_W-1:0] delay_q;

  logic [WORD_W-1:0] pmin;
  logic [WORD_W-1:0] req_ms_w;
  logic [WORD_W-1:0] span;

  logic              div_busy;
  logic              div_done;
  logic [NUM_W-1:0]  div_num;
  logic [WORD_W-1:0] div_den;
  logic [NUM_W-1:0]  div_quo;
  logic [WORD_W-1:0] div_rem;

  assign prod2    = P2_W'(prod1_q) * P2_W'(frb_pkg::MS_PER_SEC);
  assign pmin     = (div_quo[NUM_W-1:WORD_W] != '0) ? '1 : div_quo[WORD_W-1:0];
  assign req_ms_w = WORD_W'(req_ms_q);
  assign span     = maxw_q - minw_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fib_ld) begin
      fib_q <= frb_pkg::FIB_TABLE[TBL_W'(fib_idx)];
    end
    if (cmd_i.mul1_ld) begin
      prod1_q <= P1_W'(fib_q) * P1_W'(mult_q);
    end
    if (cmd_i.mul2_ld) begin
      maxw_q <= (prod2[P2_W-1:WORD_W] != '0) ? '1 : prod2[WORD_W-1:0];
    end
    if (cmd_i.pct_ld) begin
      pprod_q  <= NUM_W'(pct_q) * NUM_W'(maxw_q);
      req_ms_q <= REQ_W'(min_req_q) * REQ_W'(frb_pkg::MS_PER_SEC);
    end
    if (cmd_i.minw_ld) begin
      minw_q <= (pmin > req_ms_w) ? pmin : req_ms_w;
    end
    if (cmd_i.delay_zero) begin
      delay_q <= '0;
    end else if (cmd_i.delay_min) begin
      delay_q <= minw_q;
    end else if (cmd_i.delay_add) begin
      delay_q <= minw_q + div_rem;
    end
  end

  // Shared divider: percentage scaling first, then jitter modulo the span
  always_comb begin
    if (cmd_i.div_sel_rem) begin
      div_num = NUM_W'(rnd_q);
      div_den = span;
    end else begin
      div_num = pprod_q;
      div_den = WORD_W'(frb_pkg::PERCENT_BASE);
    end
  end

  frb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  always_comb begin
    sts_o.is_close    = func_q;
    sts_o.is_disabled = !en_q;
    sts_o.zero_max    = (maxw_q == '0);
    sts_o.min_ge_max  = (minw_q >= maxw_q);
    sts_o.div_done    = div_done;
  end

  // Output register
  logic sched;
  assign sched = !func_q && en_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_data_o.schedule      <= sched;
      out_data_o.delay_ms      <= delay_q;
      out_data_o.clear_cache   <= sched &&
                                  ((cnt_q > CNT_W'(1)) || (cnt_q >= CNT_W'(thr_q)));
      out_data_o.notify_down   <= sched && (cnt_q == CNT_W'(thr_q));
      out_data_o.notify_error  <= sched && (cnt_q != CNT_W'(thr_q));
      out_data_o.attempt_count <= cnt_q;
    end
  end

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> !div_busy)
    else $error("divider started while busy");

  a_jitter_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.delay_add |-> (minw_q < maxw_q) && (div_rem < span))
    else $error("jittered delay outside the wait window");

endmodule

`default_nettype wire

[hdl/frb_ctrl.sv]
`default_nettype none

module frb_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              out_stall_i,
  input  wire frb_pkg::frb_sts_t sts_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  output frb_pkg::frb_cmd_t      cmd_o
);

  frb_pkg::frb_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      frb_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = frb_pkg::ST_CHECK;
      end
      frb_pkg::ST_CHECK: begin
        if (sts_i.is_close || sts_i.is_disabled) state_d = frb_pkg::ST_FINISH;
        else state_d = frb_pkg::ST_FIB;
      end
      frb_pkg::ST_FIB:  state_d = frb_pkg::ST_MUL1;
      frb_pkg::ST_MUL1: state_d = frb_pkg::ST_MUL2;
      frb_pkg::ST_MUL2: state_d = frb_pkg::ST_PCT;
      frb_pkg::ST_PCT:  state_d = frb_pkg::ST_DIVQ;
      frb_pkg::ST_DIVQ: state_d = frb_pkg::ST_WAITQ;
      frb_pkg::ST_WAITQ: begin
        if (sts_i.div_done) state_d = frb_pkg::ST_MINW;
      end
      frb_pkg::ST_MINW: state_d = frb_pkg::ST_SPAN;
      frb_pkg::ST_SPAN: begin
        if (sts_i.zero_max || sts_i.min_ge_max) state_d = frb_pkg::ST_FINISH;
        else state_d = frb_pkg::ST_WAITR;
      end
      frb_pkg::ST_WAITR: begin
        if (sts_i.div_done) state_d = frb_pkg::ST_FINISH;
      end
      frb_pkg::ST_FINISH: begin
        if (slot_free) state_d = frb_pkg::ST_IDLE;
      end
      default: state_d = frb_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      frb_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      frb_pkg::ST_CHECK: begin
        cmd_o.delay_zero = sts_i.is_close || sts_i.is_disabled;
      end
      frb_pkg::ST_FIB:  cmd_o.fib_ld  = 1'b1;
      frb_pkg::ST_MUL1: cmd_o.mul1_ld = 1'b1;
      frb_pkg::ST_MUL2: cmd_o.mul2_ld = 1'b1;
      frb_pkg::ST_PCT:  cmd_o.pct_ld  = 1'b1;
      frb_pkg::ST_DIVQ: cmd_o.div_start = 1'b1;
      frb_pkg::ST_WAITQ: ;
      frb_pkg::ST_MINW: cmd_o.minw_ld = 1'b1;
      frb_pkg::ST_SPAN: begin
        cmd_o.div_sel_rem = 1'b1;
        if (sts_i.zero_max) begin
          cmd_o.delay_zero = 1'b1;
        end else if (sts_i.min_ge_max) begin
          cmd_o.delay_min = 1'b1;
        end else begin
          cmd_o.div_start = 1'b1;
        end
      end
      frb_pkg::ST_WAITR: begin
        cmd_o.div_sel_rem = 1'b1;
        cmd_o.delay_add   = sts_i.div_done;
      end
      frb_pkg::ST_FINISH: cmd_o.out_ld = slot_free;
      default: ;
    endcase
  end

  // Result slot: fill on load, drain when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= frb_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_ld |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while still pending");

  a_valid_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.out_ld))
    else $error("result valid without a load");

endmodule

`default_nettype wire

[hdl/fibonacci_reconnect_backoff.sv]
`default_nettype none

// Reconnect backoff engine. Each item is a failure event (func 0) or a tunnel
// close (func 1); each gives exactly one result item. A failure bumps the
// saturating attempt count and, with the tunnel enabled, picks a delay in the
// window [max(min_delay, percent of max), F(index) * multiplier * 1000 ms)
// using the random word as jitter, or the minimum if that window is empty, or
// zero if the max is zero. One item is in work at a time; the result register
// lets the next item enter while a result waits to be taken. For a scheduled
// reconnect the shared 40-step restoring divider runs once to scale the
// percentage minimum and once more for the jitter modulo when jitter applies.
// Configuration registers (index 0 notify threshold, 1 max Fibonacci index,
// 2 multiplier in seconds, 3 minimum percent) are to be written by the user
// only while the engine is idle; the block itself does not enforce this.
module fibonacci_reconnect_backoff #(
  parameter int FIB_INDEX_LIMIT = frb_pkg::FIB_INDEX_LIMIT_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [frb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [frb_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire frb_pkg::frb_in_t              in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output frb_pkg::frb_out_t                  out_data_o
);

  frb_pkg::frb_cmd_t cmd;
  frb_pkg::frb_sts_t sts;

  frb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .cmd_o      (cmd)
  );

  frb_datapath #(
    .FIB_INDEX_LIMIT(FIB_INDEX_LIMIT)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_data_o(out_data_o)
  );

endmodule

`default_nettype wire

[tb/frb_backoff_checker.sv]
`default_nettype none

module frb_backoff_checker #(
  parameter int FIB_INDEX_LIMIT = frb_pkg::FIB_INDEX_LIMIT_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [frb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [frb_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_stall_i,
  input  wire frb_pkg::frb_in_t              in_data_i,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_stall_i,
  input  wire frb_pkg::frb_out_t             out_data_i,
  output int                                 mismatches_o,
  output int                                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import frb_pkg::*;

  localparam int FIB_TOP_INDEX = 47;
  localparam int REPORT_LIMIT  = 10;
  localparam longint unsigned WORD_TOP = 64'hFFFF_FFFF;

  // Local copy of the configuration and the attempt counter
  logic [THR_W-1:0]    thr_q;
  logic [MAXIDX_W-1:0] max_fib_q;
  logic [MULT_W-1:0]   mult_q;
  logic [PCT_W-1:0]    pct_q;
  logic [CNT_W-1:0]    fail_run;

  frb_out_t backoff_due [$];
  int       mismatches;
  int       due_count;

  assign mismatches_o = mismatches;
  assign pending_o    = due_count;

  function automatic longint unsigned clip32(input longint unsigned v);
    return (v > WORD_TOP) ? WORD_TOP : v;
  endfunction

  // Work out the result of one item and advance the attempt counter
  function automatic frb_out_t next_backoff(input frb_in_t ev);
    frb_out_t        res;
    int unsigned     idx;
    longint unsigned fa, fb, ft;
    longint unsigned win_ms, pct_ms, floor_ms;
    res = '0;
    if (ev.func) begin
      fail_run = '0;
      return res;
    end
    if (fail_run != '1) fail_run = fail_run + 1'b1;
    res.attempt_count = fail_run;
    if (!ev.tunnel_enabled) return res;

    // Clamp the Fibonacci index and walk the sequence up to it
    idx = fail_run;
    if (idx > max_fib_q) idx = max_fib_q;
    if (idx > FIB_INDEX_LIMIT) idx = FIB_INDEX_LIMIT;
    if (idx > FIB_TOP_INDEX) idx = FIB_TOP_INDEX;
    fa = 0;
    fb = 1;
    repeat (idx) begin
      ft = fa + fb;
      fa = fb;
      fb = ft;
    end

    // Window bounds in ms; the delay stays zero for a zero maximum
    win_ms = clip32(fa * 64'(mult_q) * 64'(MS_PER_SEC));
    if (win_ms != 0) begin
      pct_ms   = clip32((64'(pct_q) * win_ms) / 64'(PERCENT_BASE));
      floor_ms = 64'(ev.min_delay_secs) * 64'(MS_PER_SEC);
      if (pct_ms > floor_ms) floor_ms = pct_ms;
      if (floor_ms >= win_ms) res.delay_ms = 32'(floor_ms);
      else res.delay_ms = 32'(floor_ms + 64'(ev.random_value) % (win_ms - floor_ms));
    end

    res.schedule     = 1'b1;
    res.clear_cache  = (fail_run > 1) || (fail_run >= CNT_W'(thr_q));
    res.notify_down  = (fail_run == CNT_W'(thr_q));
    res.notify_error = !res.notify_down;
    return res;
  endfunction

  task automatic check_field(input string field, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
                 $time, field, want, want, got, got);
    end
  endtask

  // Track configuration, queue predictions, compare delivered results
  always @(posedge clk_i or negedge rst_ni) begin
    frb_out_t due;
    if (!rst_ni) begin
      thr_q     = NOTIFY_THR_RST;
      max_fib_q = MAX_FIB_RST;
      mult_q    = WAIT_MULT_RST;
      pct_q     = MIN_PCT_RST;
      fail_run  = '0;
      backoff_due.delete();
      due_count = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NOTIFY_THR: thr_q = cfg_data_i[THR_W-1:0];
          CFG_MAX_FIB:    max_fib_q = cfg_data_i[MAXIDX_W-1:0];
          CFG_WAIT_MULT:  mult_q = cfg_data_i[MULT_W-1:0];
          CFG_MIN_PCT:    pct_q = cfg_data_i[PCT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (backoff_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result item with no prediction waiting: %p", $time, out_data_i);
        end else begin
          due = backoff_due.pop_front();
          check_field("schedule", due.schedule, out_data_i.schedule);
          check_field("delay_ms", due.delay_ms, out_data_i.delay_ms);
          check_field("clear_cache", due.clear_cache, out_data_i.clear_cache);
          check_field("notify_down", due.notify_down, out_data_i.notify_down);
          check_field("notify_error", due.notify_error, out_data_i.notify_error);
          check_field("attempt_count", due.attempt_count, out_data_i.attempt_count);
        end
      end
      if (in_valid_i && !in_stall_i) backoff_due.push_back(next_backoff(in_data_i));
      due_count = backoff_due.size();
    end
  end

  initial mismatches = 0;

endmodule

`default_nettype wire

[tb/tb_fibonacci_reconnect_backoff.sv]
`default_nettype none

module tb_fibonacci_reconnect_backoff;
  timeunit 1ns;
  timeprecision 1ps;

  import frb_pkg::*;

  localparam int FIB_LIMIT        = FIB_INDEX_LIMIT_DEF;
  localparam int CYCLE_LIMIT      = 3_000_000;
  localparam int SETTLE_CYCLES    = 12;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int COUNT_TOP        = 65535;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  frb_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  frb_out_t             out_data;

  int mismatch_count;
  int results_pending;
  int cycle_count = 0;
  bit idle_on = 1'b0;
  bit hold_out_req = 1'b0;

  fibonacci_reconnect_backoff #(
    .FIB_INDEX_LIMIT(FIB_LIMIT)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  frb_backoff_checker #(
    .FIB_INDEX_LIMIT(FIB_LIMIT)
  ) u_backoff_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .mismatches_o(mismatch_count),
    .pending_o   (results_pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Abort a hung run
  initial begin : watchdog
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Result side: random stall bursts, plus one long hold on request
  initial begin : result_stall
    forever begin
      @(posedge clk);
      if (hold_out_req) begin
        hold_out_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic frb_in_t pack_event(input logic fn, input logic en,
                                         input logic [MIN_REQ_W-1:0] min_s,
                                         input logic [WORD_W-1:0] rnd);
    frb_in_t ev;
    ev.func           = fn;
    ev.tunnel_enabled = en;
    ev.min_delay_secs = min_s;
    ev.random_value   = rnd;
    return ev;
  endfunction

  function automatic frb_in_t make_event(input logic closing);
    frb_in_t ev;
    ev.func           = closing;
    ev.tunnel_enabled = ($urandom_range(0, 99) < 85);
    case ($urandom_range(0, 5))
      0:       ev.min_delay_secs = '0;
      1:       ev.min_delay_secs = '1;
      2:       ev.min_delay_secs = MIN_REQ_W'($urandom);
      default: ev.min_delay_secs = MIN_REQ_W'($urandom_range(0, 40));
    endcase
    case ($urandom_range(0, 9))
      0:       ev.random_value = '0;
      1:       ev.random_value = '1;
      default: ev.random_value = $urandom;
    endcase
    return ev;
  endfunction

  // Offer one item, with an optional gap first; return once it is taken
  task automatic offer(input frb_in_t ev);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and hold until every predicted result has been delivered
  task automatic await_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_DAT_W-1:0] thr, input logic [CFG_DAT_W-1:0] maxfib,
                              input logic [CFG_DAT_W-1:0] mult, input logic [CFG_DAT_W-1:0] pct);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_NOTIFY_THR;
    cfg_data <= thr;
    @(posedge clk);
    cfg_idx  <= CFG_MAX_FIB;
    cfg_data <= maxfib;
    @(posedge clk);
    cfg_idx  <= CFG_WAIT_MULT;
    cfg_data <= mult;
    @(posedge clk);
    cfg_idx  <= CFG_MIN_PCT;
    cfg_data <= pct;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Runs of failures closed by a tunnel close, with a few stray closes
  task automatic run_failure_streaks(input int n_items);
    int sent;
    int run_len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 19) == 0) begin
        offer(make_event(1'b1));
        sent++;
      end
      run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      repeat (run_len) begin
        offer(make_event(1'b0));
        sent++;
      end
      offer(make_event(1'b1));
      sent++;
    end
  endtask

  initial begin : stimulus
    int k;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items at reset configuration
    offer(pack_event(1'b1, 1'b1, '1, '1));
    offer(pack_event(1'b0, 1'b1, '0, '0));
    offer(pack_event(1'b0, 1'b1, '0, '1));
    offer(pack_event(1'b0, 1'b1, '0, 32'd777));
    offer(pack_event(1'b0, 1'b0, '1, '1));
    offer(pack_event(1'b0, 1'b1, '1, 32'd5));
    offer(pack_event(1'b0, 1'b1, 16'd2, 32'd99991));
    repeat (4) offer(pack_event(1'b0, 1'b1, MIN_REQ_W'($urandom_range(0, 9)), $urandom));
    offer(pack_event(1'b1, 1'b0, '0, '0));
    offer(pack_event(1'b0, 1'b1, 16'd1, '0));
    offer(pack_event(1'b1, 1'b1, '0, '1));
    await_idle();

    // Empty window, threshold of one
    program_regs(8'd1, 8'd0, 8'd1, 8'd0);
    offer(pack_event(1'b0, 1'b1, '1, '1));
    offer(pack_event(1'b0, 1'b1, '0, 32'd42));
    offer(pack_event(1'b0, 1'b0, 16'd3, '0));
    offer(pack_event(1'b1, 1'b1, '0, '0));
    offer(pack_event(1'b0, 1'b1, '0, '1));
    await_idle();

    // Saturate the window and drive the counter to its top
    program_regs(8'd255, 8'd24, 8'd255, 8'd100);
    offer(pack_event(1'b1, 1'b0, '0, '0));
    for (k = 1; k <= COUNT_TOP + 3; k++) begin
      offer(pack_event(1'b0, ((k >= 250 && k <= 260) || k >= COUNT_TOP - 5),
                       MIN_REQ_W'($urandom), $urandom));
    end
    offer(pack_event(1'b1, 1'b1, '1, '1));
    await_idle();

    // Random streaks over a range of settings
    idle_on = 1'b1;
    program_regs(8'd255, 8'd24, 8'd255, 8'd0);
    run_failure_streaks(150);
    await_idle();

    program_regs(8'd2, 8'd31, 8'd3, 8'd50);
    run_failure_streaks(75);
    hold_out_req = 1'b1;
    run_failure_streaks(75);
    await_idle();

    program_regs(8'd1, 8'd24, 8'd1, 8'd100);
    run_failure_streaks(75);
    await_idle();
    run_failure_streaks(75);
    await_idle();

    repeat (3) begin
      program_regs(CFG_DAT_W'($urandom_range(1, 12)), CFG_DAT_W'($urandom_range(0, 24)),
                   CFG_DAT_W'($urandom_range(1, 255)), CFG_DAT_W'($urandom_range(0, 100)));
      run_failure_streaks(150);
      await_idle();
    end

    // Closing stretch without idling
    idle_on = 1'b0;
    program_regs(CFG_DAT_W'($urandom_range(1, 255)), CFG_DAT_W'($urandom_range(0, 24)),
                 CFG_DAT_W'($urandom_range(1, 255)), CFG_DAT_W'($urandom_range(0, 100)));
    run_failure_streaks(150);
    await_idle();

    if (mismatch_count == 0 && results_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

[fibonacci_reconnect_backoff.f]
hdl/frb_pkg.sv
hdl/frb_div.sv
hdl/frb_datapath.sv
hdl/frb_ctrl.sv
hdl/fibonacci_reconnect_backoff.sv
tb/frb_backoff_checker.sv
tb/tb_fibonacci_reconnect_backoff.sv
